/* rtl/arpfb_pkg.sv */
package arpfb_pkg;

  // command codes carried by an input item
  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_REPLY   = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic CFG_OWN_MAC = 1'b0;
  localparam logic CFG_OWN_IP  = 1'b1;

  localparam logic [47:0] OWN_MAC_RESET = 48'h00E93A25C229;
  localparam logic [31:0] OWN_IP_RESET  = 32'hC0A80189;

  localparam int unsigned FRAME_LEN = 42;
  localparam int unsigned BYTE_IDX_W = 6;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] peer_ip;
    logic [47:0] peer_mac;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_frame;
    logic       resolved;
    logic       last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;       // take the input item, learn peer on reply
    logic idx_inc;      // advance byte / entry index
    logic cmp;          // compare table read data against peer octet
    logic load_frame;   // load next frame byte into output register
    logic load_answer;  // load query answer into output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  in_op;
    logic table_empty;
    logic frame_last;
    logic scan_last;
    logic slot_free;
  } ctrl_stat_t;

endpackage

/* rtl/arpfb_ram.sv */
module arpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/arpfb_ctrl.sv */
module arpfb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  arpfb_pkg::ctrl_stat_t stat,
  output arpfb_pkg::ctrl_cmd_t  cmd
);
  import arpfb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_READ,
    ST_CMP,
    ST_ANSWER
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (stat.in_op)
            OP_REQUEST, OP_REPLY: state_next = ST_FRAME;
            OP_QUERY:             state_next = stat.table_empty ? ST_ANSWER : ST_READ;
            default:              state_next = ST_IDLE;
          endcase
        end
      end
      ST_FRAME: begin
        if (stat.slot_free) begin
          cmd.load_frame = 1'b1;
          cmd.idx_inc    = 1'b1;
          if (stat.frame_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_ANSWER;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_ANSWER: begin
        if (stat.slot_free) begin
          cmd.load_answer = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/arpfb_dp.sv */
module arpfb_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [47:0]          cfg_data,
  input  arpfb_pkg::in_item_t  in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output arpfb_pkg::out_item_t out_data,
  input  arpfb_pkg::ctrl_cmd_t cmd,
  output arpfb_pkg::ctrl_stat_t stat
);
  import arpfb_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (AW > BYTE_IDX_W) ? AW : BYTE_IDX_W;

  logic [47:0]   own_mac;
  logic [31:0]   own_ip;
  op_t           op;
  logic [31:0]   peer_ip;
  logic [47:0]   peer_mac;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic          hit;
  logic          table_full;
  logic          learn;
  logic [7:0]    ram_q;

  logic                      reply;
  logic [47:0]               dst_mac;
  logic [47:0]               tgt_mac;
  logic [FRAME_LEN-1:0][7:0] frame;
  logic [BYTE_IDX_W-1:0]     byte_sel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= OWN_MAC_RESET;
      own_ip  <= OWN_IP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OWN_MAC: own_mac <= cfg_data;
        CFG_OWN_IP:  own_ip  <= cfg_data[31:0];
        default:     ;
      endcase
    end
  end

  assign table_full = (count == CW'(TABLE_DEPTH));
  assign learn      = cmd.accept && (op_t'(in_data.operation) == OP_REPLY) && !table_full;

  // only the last octet of a learned ip is ever looked at
  arpfb_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ip_table (
    .clk   (clk),
    .we    (learn),
    .waddr (count[AW-1:0]),
    .wdata (in_data.peer_ip[7:0]),
    .raddr (idx[AW-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (learn) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op       <= op_t'(in_data.operation);
      peer_ip  <= in_data.peer_ip;
      peer_mac <= in_data.peer_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      hit <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.accept) begin
        hit <= 1'b0;
      end else if (cmd.cmp && (ram_q == peer_ip[7:0])) begin
        hit <= 1'b1;
      end
    end
  end

  // frame image, first byte in the top slot
  assign reply   = (op == OP_REPLY);
  assign dst_mac = reply ? peer_mac : 48'hFFFF_FFFF_FFFF;
  assign tgt_mac = reply ? peer_mac : 48'h0;
  assign frame = {dst_mac, own_mac,
                  8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04,
                  8'h00, (reply ? 8'h02 : 8'h01),
                  own_mac, own_ip, tgt_mac, peer_ip};
  assign byte_sel = BYTE_IDX_W'(FRAME_LEN - 1) - idx[BYTE_IDX_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_frame || cmd.load_answer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      out_data.frame_byte <= frame[byte_sel];
      out_data.is_frame   <= 1'b1;
      out_data.resolved   <= 1'b0;
      out_data.last       <= stat.frame_last;
    end else if (cmd.load_answer) begin
      out_data.frame_byte <= 8'h00;
      out_data.is_frame   <= 1'b0;
      out_data.resolved   <= hit;
      out_data.last       <= 1'b1;
    end
  end

  assign stat.in_op       = op_t'(in_data.operation);
  assign stat.table_empty = (count == '0);
  assign stat.frame_last  = (idx == IW'(FRAME_LEN - 1));
  assign stat.scan_last   = (({1'b0, idx} + 1'b1) == (IW + 1)'(count));
  assign stat.slot_free   = !out_valid || out_ready;

endmodule

/* rtl/arp_frame_builder_with_table.sv */
// arp frame builder with a learned-peer table. each input item is a
// command with a peer ipv4 and mac address. a request streams a 42-byte
// ethernet arp request (broadcast destination, own mac/ip as sender, peer
// ip as target); a reply first stores the peer in the table when there is
// room, then streams a 42-byte arp reply addressed to the peer; a query
// gives one result telling whether a stored entry's last ip octet equals
// the low byte of peer_ip. code 3 is taken and dropped with no result.
// sequencing: a frame item is taken and then streamed one byte per cycle,
// while the output register has room, from the byte counter into the
// output register; the next item is taken once the last byte is loaded. a
// query scans the table ram one entry per read/compare pair. own_mac and
// own_ip are written on the cfg channel (index 0 and 1); the user must do
// so only while the block is idle, which the block itself does not enforce.

module arp_frame_builder_with_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [47:0]          cfg_data,
  // command items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  arpfb_pkg::in_item_t  in_data,
  // frame bytes and query answers
  output logic                 out_valid,
  input  logic                 out_ready,
  output arpfb_pkg::out_item_t out_data
);
  import arpfb_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: idle, frame streaming, table scan, answer
  arpfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // config registers, captured item, peer table, frame mux, output register
  arpfb_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
